### hdl/u2l_pkg.sv
// shared types, constants and code tables for the utf-8 transcoder
package u2l_pkg;

  localparam logic [1:0] MODE_UTF16 = 2'd0;
  localparam logic [1:0] MODE_ASCII = 2'd1;
  localparam logic [1:0] MODE_WIN   = 2'd2;
  localparam logic [1:0] MODE_MAC   = 2'd3;

  localparam logic [1:0] REG_OUT_MODE = 2'd0;
  localparam logic [1:0] REG_UNKNOWN  = 2'd1;

  localparam int unsigned MAX_BYTES = 4;

  // one decoded job: up to four bytes ready to go
  typedef struct packed {
    logic [2:0] cnt;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
  } burst_t;

  function automatic logic [7:0] winansi_lookup(input logic [30:0] cp);
    logic [7:0] b;
    b = 8'h00;
    case (cp)
      31'h20ac: b = 8'h80; 31'h152: b = 8'h8c; 31'h160: b = 8'h8a;
      31'h178: b = 8'h9f;  31'h17d: b = 8'h8e; 31'h2022: b = 8'h95;
      31'h2c6: b = 8'h88;  31'h2020: b = 8'h86; 31'h2021: b = 8'h87;
      31'h2026: b = 8'h85; 31'h2014: b = 8'h97; 31'h2013: b = 8'h96;
      31'h192: b = 8'h83;  31'h2039: b = 8'h8b; 31'h203a: b = 8'h9b;
      31'h153: b = 8'h9c;  31'h2030: b = 8'h89; 31'h201e: b = 8'h84;
      31'h201c: b = 8'h93; 31'h201d: b = 8'h94; 31'h2018: b = 8'h91;
      31'h2019: b = 8'h92; 31'h201a: b = 8'h82; 31'h161: b = 8'h9a;
      31'h303: b = 8'h98;  31'h2122: b = 8'h99; 31'h17e: b = 8'h9e;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] macroman_lookup(input logic [30:0] cp);
    logic [7:0] b;
    b = 8'h00;
    case (cp)
      31'hc6: b = 8'hae; 31'hc1: b = 8'he7; 31'hc2: b = 8'he5; 31'hc4: b = 8'h80;
      31'hc0: b = 8'hcb; 31'hc5: b = 8'h81; 31'hc3: b = 8'hcc; 31'hc7: b = 8'h82;
      31'hc9: b = 8'h83; 31'hca: b = 8'he6; 31'hcb: b = 8'he8; 31'hc8: b = 8'he9;
      31'hcd: b = 8'hea; 31'hce: b = 8'heb; 31'hcf: b = 8'hec; 31'hcc: b = 8'hed;
      31'hd1: b = 8'h84; 31'h152: b = 8'hce; 31'hd3: b = 8'hee; 31'hd4: b = 8'hef;
      31'hd6: b = 8'h85; 31'hd2: b = 8'hf1; 31'hd8: b = 8'haf; 31'hd5: b = 8'hcd;
      31'hda: b = 8'hf2; 31'hdb: b = 8'hf3; 31'hdc: b = 8'h86; 31'hd9: b = 8'hf4;
      31'h178: b = 8'hd9; 31'he1: b = 8'h87; 31'he2: b = 8'h89; 31'h301: b = 8'hab;
      31'he4: b = 8'h8a; 31'he6: b = 8'hbe; 31'he0: b = 8'h88; 31'he5: b = 8'h8c;
      31'he3: b = 8'h8b; 31'h306: b = 8'hf9; 31'h2022: b = 8'ha5; 31'h2c7: b = 8'hff;
      31'he7: b = 8'h8d; 31'h327: b = 8'hfc; 31'ha2: b = 8'ha2; 31'h2c6: b = 8'hf6;
      31'ha9: b = 8'ha9; 31'ha4: b = 8'hdb; 31'h2020: b = 8'ha0; 31'h2021: b = 8'he0;
      31'hb0: b = 8'ha1; 31'h308: b = 8'hac; 31'hf7: b = 8'hd6; 31'h307: b = 8'hfa;
      31'h131: b = 8'hf5; 31'he9: b = 8'h8e; 31'hea: b = 8'h90; 31'heb: b = 8'h91;
      31'he8: b = 8'h8f; 31'h2026: b = 8'hc9; 31'h2014: b = 8'hd1; 31'h2013: b = 8'hd0;
      31'ha1: b = 8'hc1; 31'hfb01: b = 8'hde; 31'hfb02: b = 8'hdf; 31'h192: b = 8'hc4;
      31'h2044: b = 8'hda; 31'hdf: b = 8'ha7; 31'hab: b = 8'hc7; 31'hbb: b = 8'hc8;
      31'h2039: b = 8'hdc; 31'h203a: b = 8'hdd; 31'h30b: b = 8'hfd; 31'hed: b = 8'h92;
      31'hee: b = 8'h94; 31'hef: b = 8'h95; 31'hec: b = 8'h93; 31'hac: b = 8'hc2;
      31'h304: b = 8'hf8; 31'h3bc: b = 8'hb5; 31'hf1: b = 8'h96; 31'hf3: b = 8'h97;
      31'hf4: b = 8'h99; 31'hf6: b = 8'h9a; 31'h153: b = 8'hcf; 31'h328: b = 8'hfe;
      31'hf2: b = 8'h98; 31'h1d43: b = 8'hbb; 31'h1d52: b = 8'hbc; 31'hf8: b = 8'hbf;
      31'hf5: b = 8'h9b; 31'hb6: b = 8'ha6; 31'hb7: b = 8'he1; 31'h2030: b = 8'he4;
      31'hb1: b = 8'hb1; 31'hbf: b = 8'hc0; 31'h201e: b = 8'he3; 31'h201c: b = 8'hd2;
      31'h201d: b = 8'hd3; 31'h2018: b = 8'hd4; 31'h2019: b = 8'hd5; 31'h201a: b = 8'he2;
      31'hae: b = 8'ha8; 31'h30a: b = 8'hfb; 31'ha7: b = 8'ha4; 31'ha3: b = 8'ha3;
      31'h303: b = 8'hf7; 31'h2122: b = 8'haa; 31'hfa: b = 8'h9c; 31'hfb: b = 8'h9e;
      31'hfc: b = 8'h9f; 31'hf9: b = 8'h9d; 31'hff: b = 8'hd8; 31'ha5: b = 8'hb4;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

### hdl/u2l_in_if.sv
// input channel: one utf-8 byte per word
interface u2l_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       first_of_string;
  logic [2:0] bytes_after;
  modport source (output valid, in_byte, first_of_string, bytes_after, input ready);
  modport sink (input valid, in_byte, first_of_string, bytes_after, output ready);
endinterface

### hdl/u2l_out_if.sv
// output channel: one encoded byte per word
interface u2l_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       end_of_run;
  modport source (output valid, out_byte, end_of_run, input ready);
  modport sink (input valid, out_byte, end_of_run, output ready);
endinterface

### hdl/u2l_front.sv
// front end: utf-8 decode and encoding of each input byte into a burst
module u2l_front
  import u2l_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] ch,
  input  logic       first,
  input  logic [2:0] after,
  input  logic [1:0] mode,
  input  logic [7:0] unk,
  output burst_t     burst
);

  logic [2:0]  pend_r, pend_nxt;
  logic [30:0] acc_r, acc_nxt;

  always_comb begin
    logic [2:0]  pend;
    logic [2:0]  cnt;
    logic        do_start;
    logic        do_code;
    logic [30:0] cp;
    logic [19:0] v;
    logic [15:0] hi, lo;
    logic [7:0]  b;
    logic [7:0]  q [8];
    logic [3:0]  n;

    for (int i = 0; i < 8; i++) q[i] = 8'h00;
    n = 4'd0;
    pend = pend_r;
    acc_nxt = acc_r;
    do_start = 1'b0;
    do_code = 1'b0;
    cp = '0;
    v = '0; hi = '0; lo = '0; b = '0;
    cnt = 3'd0;

    if (first) begin
      pend = 3'd0;
      acc_nxt = '0;
      if (mode == MODE_UTF16) begin
        q[n[2:0]] = 8'hfe; n = n + 4'd1;
        q[n[2:0]] = 8'hff; n = n + 4'd1;
      end
    end
    if (pend != 3'd0) begin
      if (ch[7:6] == 2'b10) begin
        cp = {acc_nxt[24:0], ch[5:0]};
        pend = pend - 3'd1;
        acc_nxt = cp;
        if (pend == 3'd0) begin
          do_code = 1'b1;
          acc_nxt = '0;
        end
      end else begin
        pend = 3'd0;
        acc_nxt = '0;
        if (mode == MODE_UTF16) begin
          q[n[2:0]] = 8'hff; n = n + 4'd1;
          q[n[2:0]] = 8'hfd; n = n + 4'd1;
        end else begin
          q[n[2:0]] = unk; n = n + 4'd1;
        end
        do_start = 1'b1;
      end
    end else begin
      do_start = 1'b1;
    end

    if (do_code) begin
      if (mode == MODE_UTF16) begin
        if ((cp >= 31'hd800 && cp <= 31'hdfff) || cp > 31'h10ffff) begin
          q[n[2:0]] = 8'hff; n = n + 4'd1;
          q[n[2:0]] = 8'hfd; n = n + 4'd1;
        end else if (cp <= 31'hffff) begin
          q[n[2:0]] = cp[15:8]; n = n + 4'd1;
          q[n[2:0]] = cp[7:0];  n = n + 4'd1;
        end else begin
          v = cp[19:0] - 20'h10000;
          hi = {6'd0, v[19:10]} + 16'hd800;
          lo = {6'd0, v[9:0]} + 16'hdc00;
          q[n[2:0]] = hi[15:8]; n = n + 4'd1;
          q[n[2:0]] = hi[7:0];  n = n + 4'd1;
          q[n[2:0]] = lo[15:8]; n = n + 4'd1;
          q[n[2:0]] = lo[7:0];  n = n + 4'd1;
        end
      end else begin
        case (mode)
          MODE_WIN: begin
            if (cp >= 31'd160 && cp < 31'd256) b = cp[7:0];
            else b = winansi_lookup(cp);
          end
          MODE_MAC: b = macroman_lookup(cp);
          default:  b = 8'h00;
        endcase
        if (b == 8'h00) b = unk;
        q[n[2:0]] = b; n = n + 4'd1;
      end
    end

    if (do_start) begin
      if (!ch[7]) begin
        if (mode == MODE_UTF16) begin
          q[n[2:0]] = 8'h00; n = n + 4'd1;
        end
        q[n[2:0]] = ch; n = n + 4'd1;
      end else begin
        casez (ch)
          8'b10??_????: cnt = 3'd0;
          8'b110?_????: cnt = 3'd1;
          8'b1110_????: cnt = 3'd2;
          8'b1111_0???: cnt = 3'd3;
          8'b1111_10??: cnt = 3'd4;
          8'b1111_110?: cnt = 3'd5;
          default:      cnt = 3'd6;
        endcase
        if (cnt == 3'd0 || cnt > 3'd5 || after < cnt) begin
          if (mode == MODE_UTF16) begin
            q[n[2:0]] = 8'hff; n = n + 4'd1;
            q[n[2:0]] = 8'hfd; n = n + 4'd1;
          end else begin
            q[n[2:0]] = unk; n = n + 4'd1;
          end
        end else begin
          pend = cnt;
          acc_nxt = {25'd0, ch[5:0] & (6'h3f >> cnt)};
        end
      end
    end

    pend_nxt = pend;
    // at most four bytes go out per input word
    burst.cnt = (n > 4'd4) ? 3'd4 : n[2:0];
    burst.b0 = q[0];
    burst.b1 = q[1];
    burst.b2 = q[2];
    burst.b3 = q[3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 3'd0;
      acc_r <= '0;
    end else if (take) begin
      pend_r <= pend_nxt;
      acc_r <= acc_nxt;
    end
  end

endmodule

### hdl/u2l_queue.sv
// short burst queue between front and back
module u2l_queue
  import u2l_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  burst_t wdata,
  output logic   full,
  input  logic   pop,
  output logic   empty,
  output burst_t rdata
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  burst_t         mem_r [DEPTH];
  logic [AW-1:0]  wp_r, rp_r;
  logic [AW:0]    cnt_r;

  assign full  = (cnt_r == (AW+1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule

### hdl/u2l_back.sv
// back end: serializes each burst into output words
module u2l_back
  import u2l_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       empty,
  input  burst_t     burst,
  output logic       pop,
  output logic       valid,
  input  logic       ready,
  output logic [7:0] data,
  output logic       last
);
  logic [1:0] idx_r;

  always_comb begin
    case (idx_r)
      2'd0:    data = burst.b0;
      2'd1:    data = burst.b1;
      2'd2:    data = burst.b2;
      default: data = burst.b3;
    endcase
  end

  assign valid = !empty;
  assign last  = ({1'b0, idx_r} == burst.cnt - 3'd1);
  assign pop   = valid && ready && last;

  always_ff @(posedge clk) begin
    if (!rst_n) idx_r <= 2'd0;
    else if (valid && ready) idx_r <= last ? 2'd0 : idx_r + 2'd1;
  end
endmodule

### hdl/utf8_to_legacy_transcoder_unit.sv
// top level: utf-8 to utf-16be / ascii / winansi / macroman transcoder
// an accepted byte's burst is registered in the queue and offered after earlier bursts drain
// throughput: one input word per cycle while the output side keeps up; an
//   input producing k words holds the output side until all k words are taken
// the burst queue (QUEUE_DEPTH entries, two by default) lets input continue while output drains
// reset (synchronous, rst_n low): empty queue, no sequence pending, mode utf-16be, unknown 0x3f
module utf8_to_legacy_transcoder_unit
  import u2l_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  u2l_in_if.sink     in_ch,
  u2l_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [7:0] cfg_data
);

  // configuration registers
  logic [1:0] mode_r;
  logic [7:0] unk_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_UTF16;
      unk_r <= 8'h3f;
    end else if (cfg_we) begin
      case ({1'b0, cfg_index})
        REG_OUT_MODE: mode_r <= cfg_data[1:0];
        REG_UNKNOWN:  unk_r <= cfg_data;
        default: ;
      endcase
    end
  end

  burst_t fb, qb;
  logic   full, empty, pop, take, push;

  // accept whenever the queue has room
  assign in_ch.ready = !full;
  assign take = in_ch.valid && !full;
  // bytes that make no output are not queued
  assign push = take && (fb.cnt != 3'd0);

  u2l_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .ch    (in_ch.in_byte),
    .first (in_ch.first_of_string),
    .after (in_ch.bytes_after),
    .mode  (mode_r),
    .unk   (unk_r),
    .burst (fb)
  );

  u2l_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (fb),
    .full  (full),
    .pop   (pop),
    .empty (empty),
    .rdata (qb)
  );

  u2l_back u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .empty (empty),
    .burst (qb),
    .pop   (pop),
    .valid (out_ch.valid),
    .ready (out_ch.ready),
    .data  (out_ch.out_byte),
    .last  (out_ch.end_of_run)
  );

endmodule
